[rtl/assert_macros.svh]
// assertion macros used by the port-level checker
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// when ante holds at an edge, cons must hold at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/pcc_pkg.sv]
// shared constants, codes and types of the clamped pid controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    // item operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration port
    localparam int APB_DW = 64;
    localparam int APB_AW = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN   = 3'd6;

    // datapath widths
    localparam int VAL_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int DLIM_W  = 24;
    localparam int ILIM_W  = 47;
    localparam int ERR_W   = 17;
    localparam int DELTA_W = 18;
    localparam int DIFF_W  = 25;
    localparam int INTEG_W = 48;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 64;
    localparam int IQ_W    = 39;
    localparam int IQ_LO_W = 19;
    localparam int FRAC_SHIFT = 16;

    localparam logic [VAL_W-1:0] MS_PER_SEC = 16'd1000;

    // iterative divider
    localparam int DIV_W      = 48;
    localparam int DIV_DVS_W  = 16;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

[rtl/pcc_div.sv]
// iterative unsigned divider, restoring, several quotient bits per cycle
// depends on pcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcc_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [pcc_pkg::DIV_W-1:0]     i_dividend,
    input  wire [pcc_pkg::DIV_DVS_W-1:0] i_divisor,
    output pcc_pkg::t_div_res            o_res
);
    import pcc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DVS_W-1:0] r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_DVS_W-1:0] r_dvs;

    logic [DIV_DVS_W-1:0] n_rem;
    logic [DIV_W-1:0]     n_quo;
    logic [DIV_DVS_W:0]   sh;

    // DIV_RADIX restoring steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        sh    = '0;
        for (int k = 0; k < DIV_RADIX; k++) begin
            sh    = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (sh >= {1'b0, r_dvs}) begin
                n_rem    = DIV_DVS_W'(sh - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = sh[DIV_DVS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quo;

endmodule

`default_nettype wire

[rtl/pid_controller_clamped_unit.sv]
// clamped pid controller step: sequencer, shared multiplier, state and config registers
// depends on pcc_pkg and pcc_div
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel i_valid / o_stall carries one item: i_operation, i_set_point,
//   i_measured_value, i_step_ms; an item is taken at an edge with valid high, stall low
// - a step item yields one result (o_drive, o_drive_clamped) on o_valid / i_stall;
//   a clear item zeroes integral and previous error, re-arms the first step flag,
//   and yields no result
// - a step item keeps o_stall high until its result is loaded into the output
//   register, so no new item is taken before then; that time is set by two passes
//   through the 4-bit-per-cycle divider (derivative over step_ms, then integral over
//   1000) and six uses of the single 25x25 multiplier
// - a clear item is absorbed in the accepting cycle; o_stall stays low
// - a finished result waits in an output register; the block takes new items while
//   it waits, and only the final load of the next result holds off if i_stall is high
// - reset (synchronous, active low) empties the output, zeroes the controller state,
//   sets the first step flag and returns the configuration registers to their reset values
// - registers sit at byte address 8*index on the 64-bit apb port; write only while idle

module pid_controller_clamped_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_operation,
    input  wire  [pcc_pkg::VAL_W-1:0]    i_set_point,
    input  wire  [pcc_pkg::VAL_W-1:0]    i_measured_value,
    input  wire  [pcc_pkg::VAL_W-1:0]    i_step_ms,
    // output channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [pcc_pkg::VAL_W-1:0]    o_drive,
    output logic                         o_drive_clamped,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [pcc_pkg::APB_AW-1:0]   paddr,
    input  wire  [pcc_pkg::APB_DW-1:0]   pwdata,
    output logic [pcc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import pcc_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MDEL  = 12'b0000_0000_0010,  // delta * 1000
        S_MINT  = 12'b0000_0000_0100,  // previous error * dt, start derivative divide
        S_UPDI  = 12'b0000_0000_1000,  // integral update and clamp
        S_WDIV1 = 12'b0000_0001_0000,  // wait derivative quotient, start integral / 1000
        S_WDIV2 = 12'b0000_0010_0000,  // wait integral quotient
        S_MP    = 12'b0000_0100_0000,  // gain_p * error
        S_MD    = 12'b0000_1000_0000,  // gain_d * derivative
        S_MIL   = 12'b0001_0000_0000,  // gain_i * low part of integral / 1000
        S_MIH   = 12'b0010_0000_0000,  // gain_i * high part
        S_ACC   = 12'b0100_0000_0000,  // last accumulate
        S_OUT   = 12'b1000_0000_0000   // clamp and load output register
    } t_state;

    // configuration registers
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic [DLIM_W-1:0]        r_deriv_limit;
    logic [ILIM_W-1:0]        r_integ_limit;
    logic signed [VAL_W-1:0]  r_drive_max, r_drive_min;

    // controller state
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic                      r_first;

    // per-item working registers
    t_state                    r_state, n_state;
    logic signed [ERR_W-1:0]   r_err;
    logic [VAL_W-1:0]          r_dt;
    logic                      r_skip;
    logic                      r_dneg, r_dnz;
    logic                      r_ineg;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [IQ_W-1:0]    r_iq;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    // output register
    logic                      r_out_vld;
    logic [VAL_W-1:0]          r_drive;
    logic                      r_clamped;

    logic                      in_take;
    logic                      out_free;
    logic                      cfg_wr;
    logic [CFG_IDX_W-1:0]      cfg_idx;

    logic signed [DELTA_W-1:0] delta;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]         prod_abs;
    logic [INTEG_W-1:0]        integ_abs;
    logic signed [INTEG_W:0]   isum, ilim, isat;
    logic [DIV_W-1:0]          dmag;
    logic signed [DIFF_W-1:0]  diff_val;
    logic signed [IQ_W-1:0]    iq_val;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-FRAC_SHIFT-1:0] drive_w, dmax_w, dmin_w;

    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DIV_DVS_W-1:0]      div_divisor;
    t_div_res                  div_res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[APB_AW-1:APB_AW-CFG_IDX_W];

    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;

    assign o_valid         = r_out_vld;
    assign o_drive         = r_drive;
    assign o_drive_clamped = r_clamped;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= '0;
            r_gain_i      <= '0;
            r_gain_d      <= '0;
            r_deriv_limit <= '1;
            r_integ_limit <= '1;
            r_drive_max   <= {1'b0, {(VAL_W-1){1'b1}}};
            r_drive_min   <= {1'b1, {(VAL_W-1){1'b0}}};
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_GAIN_P:      r_gain_p      <= pwdata[GAIN_W-1:0];
                CFG_GAIN_I:      r_gain_i      <= pwdata[GAIN_W-1:0];
                CFG_GAIN_D:      r_gain_d      <= pwdata[GAIN_W-1:0];
                CFG_DERIV_LIMIT: r_deriv_limit <= pwdata[DLIM_W-1:0];
                CFG_INTEG_LIMIT: r_integ_limit <= pwdata[ILIM_W-1:0];
                CFG_DRIVE_MAX:   r_drive_max   <= pwdata[VAL_W-1:0];
                CFG_DRIVE_MIN:   r_drive_min   <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero-extended
    always_comb begin
        case (cfg_idx)
            CFG_GAIN_P:      prdata = APB_DW'(unsigned'(r_gain_p));
            CFG_GAIN_I:      prdata = APB_DW'(unsigned'(r_gain_i));
            CFG_GAIN_D:      prdata = APB_DW'(unsigned'(r_gain_d));
            CFG_DERIV_LIMIT: prdata = APB_DW'(r_deriv_limit);
            CFG_INTEG_LIMIT: prdata = APB_DW'(r_integ_limit);
            CFG_DRIVE_MAX:   prdata = APB_DW'(unsigned'(r_drive_max));
            CFG_DRIVE_MIN:   prdata = APB_DW'(unsigned'(r_drive_min));
            default:         prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    // operand select per sequencer step, product registered
    always_comb begin
        case (r_state)
            S_MDEL: begin
                mul_a = MUL_W'(delta);
                mul_b = $signed({{(MUL_W-VAL_W){1'b0}}, MS_PER_SEC});
            end
            S_MINT: begin
                mul_a = MUL_W'(r_prev_err);
                mul_b = $signed({{(MUL_W-VAL_W){1'b0}}, r_dt});
            end
            S_MP: begin
                mul_a = MUL_W'(r_gain_p);
                mul_b = MUL_W'(r_err);
            end
            S_MD: begin
                mul_a = MUL_W'(r_gain_d);
                mul_b = r_diff;
            end
            S_MIL: begin
                mul_a = MUL_W'(r_gain_i);
                mul_b = $signed({{(MUL_W-IQ_LO_W){1'b0}}, r_iq[IQ_LO_W-1:0]});
            end
            S_MIH: begin
                mul_a = MUL_W'(r_gain_i);
                mul_b = MUL_W'($signed(r_iq[IQ_W-1:IQ_LO_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ---------------- datapath helpers ----------------
    assign delta     = DELTA_W'(r_err) - DELTA_W'(r_prev_err);
    assign prod_abs  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign integ_abs = r_integ[INTEG_W-1] ? INTEG_W'(-r_integ) : INTEG_W'(r_integ);

    // integral: add previous error * dt, clamp symmetric to the limit
    assign isum = (INTEG_W+1)'(r_integ) + $signed(r_prod[INTEG_W:0]);
    assign ilim = $signed({2'b00, r_integ_limit});
    always_comb begin
        if (isum > ilim) begin
            isat = ilim;
        end else if (isum < -ilim) begin
            isat = -ilim;
        end else begin
            isat = isum;
        end
    end

    // derivative magnitude from quotient, then sign of delta
    always_comb begin
        if (r_dt == '0) begin
            dmag = r_dnz ? DIV_W'(r_deriv_limit) : '0;
        end else if (div_res.quot > DIV_W'(r_deriv_limit)) begin
            dmag = DIV_W'(r_deriv_limit);
        end else begin
            dmag = div_res.quot;
        end
        if (r_skip) begin
            diff_val = '0;
        end else if (r_dneg) begin
            diff_val = -$signed(DIFF_W'(dmag));
        end else begin
            diff_val = $signed(DIFF_W'(dmag));
        end
    end

    // integral / 1000, truncated toward zero
    assign iq_val = r_ineg ? -$signed(IQ_W'(div_res.quot)) : $signed(IQ_W'(div_res.quot));

    // product sign-extended for accumulation
    assign prod_ext = ACC_W'(r_prod);

    // floor to Q8.8 is an arithmetic shift; clamp against sign-extended bounds
    assign drive_w = r_acc[ACC_W-1:FRAC_SHIFT];
    assign dmax_w  = (ACC_W-FRAC_SHIFT)'(r_drive_max);
    assign dmin_w  = (ACC_W-FRAC_SHIFT)'(r_drive_min);

    // ---------------- shared divider ----------------
    always_comb begin
        div_start    = 1'b0;
        div_dividend = prod_abs[DIV_W-1:0];
        div_divisor  = r_dt;
        case (r_state)
            S_MINT: begin
                div_start = 1'b1;
            end
            S_WDIV1: begin
                div_start    = div_res.done;
                div_dividend = integ_abs;
                div_divisor  = MS_PER_SEC;
            end
            default: ;
        endcase
    end

    pcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_take && i_operation == OP_STEP) n_state = S_MDEL;
            S_MDEL:  n_state = S_MINT;
            S_MINT:  n_state = S_UPDI;
            S_UPDI:  n_state = S_WDIV1;
            S_WDIV1: if (div_res.done) n_state = S_WDIV2;
            S_WDIV2: if (div_res.done) n_state = S_MP;
            S_MP:    n_state = S_MD;
            S_MD:    n_state = S_MIL;
            S_MIL:   n_state = S_MIH;
            S_MIH:   n_state = S_ACC;
            S_ACC:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_integ    <= '0;
            r_prev_err <= '0;
            r_first    <= 1'b1;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_take && i_operation == OP_CLEAR) begin
                r_integ    <= '0;
                r_prev_err <= '0;
                r_first    <= 1'b1;
            end
            if (r_state == S_UPDI) begin
                r_integ    <= r_skip ? '0 : INTEG_W'(isat);
                r_prev_err <= r_err;
                r_first    <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_err  <= ERR_W'($signed(i_set_point)) - ERR_W'($signed(i_measured_value));
            r_dt   <= i_step_ms;
            r_skip <= r_first;
        end
        if (r_state == S_MDEL) begin
            r_dneg <= delta[DELTA_W-1];
            r_dnz  <= (delta != '0);
        end
        if (r_state == S_WDIV1 && div_res.done) begin
            r_diff <= diff_val;
            r_ineg <= r_integ[INTEG_W-1];
        end
        if (r_state == S_WDIV2 && div_res.done) begin
            r_iq <= iq_val;
        end
        case (r_state)
            S_MD:    r_acc <= prod_ext;
            S_MIL:   r_acc <= r_acc + prod_ext;
            S_MIH:   r_acc <= r_acc + prod_ext;
            S_ACC:   r_acc <= r_acc + (prod_ext <<< IQ_LO_W);
            default: ;
        endcase
        if (r_state == S_OUT && out_free) begin
            if (drive_w > dmax_w) begin
                r_drive   <= r_drive_max;
                r_clamped <= 1'b1;
            end else if (drive_w < dmin_w) begin
                r_drive   <= r_drive_min;
                r_clamped <= 1'b1;
            end else begin
                r_drive   <= drive_w[VAL_W-1:0];
                r_clamped <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/pcc_checker.sv]
// port-level checker of the clamped pid controller, bound to the top level
// depends on pcc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pcc_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_valid,
    input wire                       o_stall,
    input wire                       i_operation,
    input wire                       o_valid,
    input wire                       i_stall,
    input wire [pcc_pkg::VAL_W-1:0]  o_drive,
    input wire                       o_drive_clamped
);
    import pcc_pkg::*;

    logic in_take;
    logic step_take;

    assign in_take   = i_valid && !o_stall;
    assign step_take = in_take && (i_operation == OP_STEP);

    // a step item keeps the block busy on the following cycle
    `ASSERT_NEXT(a_step_busy, i_clk, i_rst_n, step_take, o_stall)

    // no item makes a result appear on the very next cycle
    `ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_take && !o_valid, !o_valid)

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // a stalled result does not change
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
                 $stable(o_drive) && $stable(o_drive_clamped))

endmodule

bind pid_controller_clamped_unit pcc_checker u_pcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_operation     (i_operation),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_drive         (o_drive),
    .o_drive_clamped (o_drive_clamped)
);

`default_nettype wire

[test/pcc_drive_checker.sv]
// checker of the clamped pid controller: tracks register writes, predicts every drive
// result from the accepted items and compares it with what the block hands out
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_drive_checker
    import pcc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input channel, as seen at the block
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  wire                 i_operation,
    input  wire  [VAL_W-1:0]    i_set_point,
    input  wire  [VAL_W-1:0]    i_measured_value,
    input  wire  [VAL_W-1:0]    i_step_ms,
    // output channel
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  wire  [VAL_W-1:0]    i_drive,
    input  wire                 i_drive_clamped,
    // register port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire                 pready,
    input  wire  [APB_AW-1:0]   paddr,
    input  wire  [APB_DW-1:0]   pwdata,
    // status for the top
    output int                  o_mismatch_cnt,
    output int                  o_pending_cnt
);

    localparam longint MILLIS_PER_SEC = 1000;
    localparam int     REPORT_MAX     = 10;

    typedef struct packed {
        logic [VAL_W-1:0] drive;
        logic             clamped;
    } drive_res_t;

    // register copies
    longint gain_p = 0;
    longint gain_i = 0;
    longint gain_d = 0;
    longint lim_deriv = 64'd16777215;
    longint lim_integ = 64'd140737488355327;
    longint drive_hi = 32767;
    longint drive_lo = -32768;

    // controller state
    longint integ_acc = 0;
    longint last_err = 0;
    bit     first_pending = 1'b1;

    drive_res_t drive_expect_q[$];
    int         mismatch_cnt = 0;

    task automatic predict_drive(input logic [VAL_W-1:0] sp_bits,
                                 input logic [VAL_W-1:0] mv_bits,
                                 input logic [VAL_W-1:0] ms_bits,
                                 output drive_res_t res);
        longint err;
        longint delta;
        longint dt;
        longint deriv;
        longint total;
        longint level;
        err = longint'($signed(sp_bits)) - longint'($signed(mv_bits));
        dt = longint'(ms_bits);
        delta = err - last_err;
        if (first_pending) begin
            deriv = 0;
            integ_acc = 0;
        end else begin
            // zero elapsed time saturates by the sign of the change
            if (dt == 0) begin
                deriv = (delta > 0) ? lim_deriv : ((delta < 0) ? -lim_deriv : 0);
            end else begin
                deriv = (delta * MILLIS_PER_SEC) / dt;
            end
            if (deriv > lim_deriv) begin
                deriv = lim_deriv;
            end else if (deriv < -lim_deriv) begin
                deriv = -lim_deriv;
            end
            integ_acc = integ_acc + last_err * dt;
            if (integ_acc > lim_integ) begin
                integ_acc = lim_integ;
            end else if (integ_acc < -lim_integ) begin
                integ_acc = -lim_integ;
            end
        end
        last_err = err;
        first_pending = 1'b0;
        total = gain_p * err + gain_i * (integ_acc / MILLIS_PER_SEC) + gain_d * deriv;
        level = total >>> FRAC_SHIFT;
        res.clamped = 1'b0;
        // upper clamp wins when the limits cross
        if (level > drive_hi) begin
            level = drive_hi;
            res.clamped = 1'b1;
        end else if (level < drive_lo) begin
            level = drive_lo;
            res.clamped = 1'b1;
        end
        res.drive = level[VAL_W-1:0];
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX) begin
            $display("[%0t] drive check: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        drive_res_t got;
        drive_res_t want;
        if (!i_rst_n) begin
            gain_p = 0;
            gain_i = 0;
            gain_d = 0;
            lim_deriv = 64'd16777215;
            lim_integ = 64'd140737488355327;
            drive_hi = 32767;
            drive_lo = -32768;
            integ_acc = 0;
            last_err = 0;
            first_pending = 1'b1;
            drive_expect_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:3])
                    CFG_GAIN_P:      gain_p = longint'($signed(pwdata[GAIN_W-1:0]));
                    CFG_GAIN_I:      gain_i = longint'($signed(pwdata[GAIN_W-1:0]));
                    CFG_GAIN_D:      gain_d = longint'($signed(pwdata[GAIN_W-1:0]));
                    CFG_DERIV_LIMIT: lim_deriv = longint'(pwdata[DLIM_W-1:0]);
                    CFG_INTEG_LIMIT: lim_integ = longint'(pwdata[ILIM_W-1:0]);
                    CFG_DRIVE_MAX:   drive_hi = longint'($signed(pwdata[VAL_W-1:0]));
                    CFG_DRIVE_MIN:   drive_lo = longint'($signed(pwdata[VAL_W-1:0]));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.drive = i_drive;
                got.clamped = i_drive_clamped;
                if (drive_expect_q.size() == 0) begin
                    note_mismatch($sformatf("result with none expected: drive=%0d clamped=%b",
                                            $signed(got.drive), got.clamped));
                end else begin
                    want = drive_expect_q.pop_front();
                    if (got.drive !== want.drive || got.clamped !== want.clamped) begin
                        note_mismatch($sformatf(
                            "exp drive=%0d clamped=%b, got drive=%0d clamped=%b",
                            $signed(want.drive), want.clamped,
                            $signed(got.drive), got.clamped));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_CLEAR) begin
                    integ_acc = 0;
                    last_err = 0;
                    first_pending = 1'b1;
                end else begin
                    predict_drive(i_set_point, i_measured_value, i_step_ms, want);
                    drive_expect_q.push_back(want);
                end
            end
        end
        o_pending_cnt <= drive_expect_q.size();
        o_mismatch_cnt <= mismatch_cnt;
    end

endmodule

[test/tb_pid_controller_clamped_unit.sv]
// top of the clamped pid controller testbench: clock, reset, item and register stimulus,
// receiver stalls and the verdict; depends on pcc_pkg, pcc_drive_checker and the block
`timescale 1ns / 1ps

module tb_pid_controller_clamped_unit;
    import pcc_pkg::*;

    localparam int     LATENCY_CYCLES = 40;      // a bit over the result latency
    localparam int     DRAIN_LIMIT    = 4000;    // cycles allowed for results to drain
    localparam int     LONG_HOLD      = 400;     // receiver hold, long enough to back up
    localparam int     PHASE_ITEMS    = 125;
    localparam longint RUN_LIMIT_NS   = 64'd5_000_000;

    logic               i_clk;
    logic               rst_n;

    // input channel
    logic               item_valid;
    logic               item_stall;
    logic               item_op;
    logic [VAL_W-1:0]   set_point;
    logic [VAL_W-1:0]   measured;
    logic [VAL_W-1:0]   step_ms;

    // output channel
    logic               res_valid;
    logic               res_stall;
    logic [VAL_W-1:0]   drive;
    logic               drive_clamped;

    // register port
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 mismatch_cnt;
    int                 pending_cnt;

    // idling switches and the long-hold request for the receiver process
    bit                 tx_idle_on = 1'b0;
    bit                 rx_idle_on = 1'b0;
    int                 hold_req = 0;

    pid_controller_clamped_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_valid          (item_valid),
        .o_stall          (item_stall),
        .i_operation      (item_op),
        .i_set_point      (set_point),
        .i_measured_value (measured),
        .i_step_ms        (step_ms),
        .o_valid          (res_valid),
        .i_stall          (res_stall),
        .o_drive          (drive),
        .o_drive_clamped  (drive_clamped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // watches both channels and the register port beside the block
    pcc_drive_checker drive_chk (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (item_valid),
        .i_in_stall       (item_stall),
        .i_operation      (item_op),
        .i_set_point      (set_point),
        .i_measured_value (measured),
        .i_step_ms        (step_ms),
        .i_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .i_drive          (drive),
        .i_drive_clamped  (drive_clamped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .o_mismatch_cnt   (mismatch_cnt),
        .o_pending_cnt    (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or loses results
    initial begin
        #(RUN_LIMIT_NS);
        $display("pid_controller_clamped_unit: mismatch");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request so the block
    // backs up and has to stall its input
    initial begin : receiver
        int hold_seen;
        int n;
        hold_seen = 0;
        res_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                res_stall <= 1'b1;
                for (n = 0; n < LONG_HOLD; n++) @(posedge i_clk);
                res_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                res_stall <= 1'b0;
            end
        end
    end

    // offer one item and hold it until taken; called at a clock edge, returns at one
    task automatic offer_item(input logic op, input logic [VAL_W-1:0] sp,
                              input logic [VAL_W-1:0] mv, input logic [VAL_W-1:0] ms);
        item_valid <= 1'b1;
        item_op <= op;
        set_point <= sp;
        measured <= mv;
        step_ms <= ms;
        do @(posedge i_clk); while (item_stall);
        // random gap after the item, lowered valid while idle
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // one register write: setup cycle, then access until pready
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // writes every register; only called with the block idle
    task automatic apply_settings(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                                  input logic [GAIN_W-1:0] gd, input logic [DLIM_W-1:0] dl,
                                  input logic [ILIM_W-1:0] il, input logic [VAL_W-1:0] dmax,
                                  input logic [VAL_W-1:0] dmin);
        write_reg(CFG_GAIN_P, APB_DW'(gp));
        write_reg(CFG_GAIN_I, APB_DW'(gi));
        write_reg(CFG_GAIN_D, APB_DW'(gd));
        write_reg(CFG_DERIV_LIMIT, APB_DW'(dl));
        write_reg(CFG_INTEG_LIMIT, APB_DW'(il));
        write_reg(CFG_DRIVE_MAX, APB_DW'(dmax));
        write_reg(CFG_DRIVE_MIN, APB_DW'(dmin));
    endtask

    // stop sending, wait for every expected result, then let the pipeline go quiet
    task automatic settle();
        int n;
        item_valid <= 1'b0;
        // let the pending count take in an item accepted at the current edge
        @(posedge i_clk);
        for (n = 0; n < DRAIN_LIMIT && pending_cnt != 0; n++) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    // gain within about +/-2.0 in Q8.16, so outputs are not always pinned
    function automatic logic [GAIN_W-1:0] gain_near_unity();
        return GAIN_W'(int'($urandom_range(0, 262143)) - 131072);
    endfunction

    // mostly step items with random content, the odd clear to restart the state
    task automatic run_random(input int count);
        logic             op;
        logic [VAL_W-1:0] sp;
        logic [VAL_W-1:0] mv;
        logic [VAL_W-1:0] ms;
        int               k;
        for (k = 0; k < count; k++) begin
            op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_STEP;
            case ($urandom_range(0, 3))
                0: begin
                    sp = VAL_W'($urandom);
                    mv = VAL_W'($urandom);
                end
                1: begin
                    // tracking: measurement close to the set point
                    sp = VAL_W'($urandom);
                    mv = sp + VAL_W'($urandom_range(0, 1023)) - VAL_W'(512);
                end
                2: begin
                    sp = VAL_W'($urandom_range(0, 511)) - VAL_W'(256);
                    mv = VAL_W'($urandom_range(0, 511)) - VAL_W'(256);
                end
                default: begin
                    sp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    mv = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                end
            endcase
            case ($urandom_range(0, 15))
                0:       ms = '0;
                1:       ms = VAL_W'($urandom);
                2:       ms = 16'hFFFF;
                default: ms = VAL_W'($urandom_range(1, 50));
            endcase
            offer_item(op, sp, mv, ms);
        end
    endtask

    initial begin : stimulus
        // every input known from time zero
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item_op <= OP_STEP;
        set_point <= '0;
        measured <= '0;
        step_ms <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // directed: unity p gain, small i and d gains, drive clamped to +/-64.0
        apply_settings(24'h010000, 24'h004000, 24'h000100, 24'd20000, 47'd5000000,
                       16'h4000, 16'hC000);
        offer_item(OP_STEP, 16'h0000, 16'h0000, 16'd10);      // first step after reset
        offer_item(OP_STEP, 16'h7FFF, 16'h8000, 16'd1);       // largest positive error
        offer_item(OP_STEP, 16'h8000, 16'h7FFF, 16'd0);       // zero dt, negative change
        offer_item(OP_STEP, 16'h8000, 16'h7FFF, 16'd0);       // zero dt, no change
        offer_item(OP_STEP, 16'h0100, 16'h0000, 16'd0);       // zero dt, positive change
        offer_item(OP_STEP, 16'h0100, 16'h0000, 16'hFFFF);    // longest dt
        offer_item(OP_STEP, 16'h0000, 16'h0000, 16'd1000);
        offer_item(OP_CLEAR, 16'h1234, 16'h4321, 16'd5);
        offer_item(OP_STEP, 16'h7FFF, 16'h8000, 16'd0);       // first step after clear
        offer_item(OP_STEP, 16'h7FFF, 16'h8000, 16'hFFFF);    // integral runs into its limit
        offer_item(OP_STEP, 16'h7FFF, 16'h8000, 16'hFFFF);
        offer_item(OP_STEP, 16'h8000, 16'h7FFF, 16'hFFFF);
        offer_item(OP_STEP, 16'h8000, 16'h7FFF, 16'hFFFF);    // negative integral limit
        offer_item(OP_STEP, 16'h8000, 16'h7FFF, 16'hFFFF);
        offer_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_item(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);   // clear twice in a row
        offer_item(OP_STEP, 16'hFFFF, 16'h0001, 16'd3);
        offer_item(OP_STEP, 16'h1234, 16'h1200, 16'd7);       // small errors, no clamp
        offer_item(OP_STEP, 16'h1240, 16'h1200, 16'd7);
        offer_item(OP_STEP, 16'h1200, 16'h1240, 16'd13);
        offer_item(OP_STEP, 16'h1200, 16'h1200, 16'd13);
        offer_item(OP_STEP, 16'h0000, 16'h7FFF, 16'd2);
        settle();

        // extreme gains and limits wide open; the receiver holds off at the start
        apply_settings(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 47'h7FFF_FFFF_FFFF,
                       16'h7FFF, 16'h8000);
        hold_req = hold_req + 1;
        run_random(PHASE_ITEMS);
        settle();

        // zero limits everywhere; sender pauses for a full drain halfway
        apply_settings(gain_near_unity(), gain_near_unity(), gain_near_unity(), '0, '0,
                       '0, '0);
        run_random(PHASE_ITEMS / 2);
        settle();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        settle();

        // crossed drive limits: the upper clamp takes priority
        apply_settings(24'h010000, GAIN_W'($urandom), 24'h800000,
                       DLIM_W'($urandom_range(0, 5000)), ILIM_W'($urandom_range(0, 100000)),
                       16'hFC18, 16'h03E8);
        run_random(PHASE_ITEMS);
        settle();

        // moderate random setting
        apply_settings(gain_near_unity(), gain_near_unity(), gain_near_unity(),
                       DLIM_W'($urandom), ILIM_W'($urandom_range(0, 32'h3FFF_FFFF)),
                       VAL_W'($urandom_range(0, 32767)),
                       VAL_W'(-int'($urandom_range(0, 32768))));
        run_random(PHASE_ITEMS);
        settle();

        // every register fully random
        apply_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                       DLIM_W'($urandom), ILIM_W'({$urandom, $urandom}),
                       VAL_W'($urandom), VAL_W'($urandom));
        run_random(PHASE_ITEMS);
        settle();

        // last stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_settings(gain_near_unity(), gain_near_unity(), gain_near_unity(),
                       DLIM_W'($urandom_range(0, 200000)),
                       ILIM_W'($urandom_range(0, 10000000)), 16'h3000, 16'hD000);
        run_random(PHASE_ITEMS);
        settle();

        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("pid_controller_clamped_unit: match");
        end else begin
            $display("pid_controller_clamped_unit: mismatch");
        end
        $finish;
    end

endmodule
